FILE: hw/rtl/k_way_sorted_merge_assert.svh
// assertion macros for the sorted merge block
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define KWSM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("k_way_sorted_merge check failed");

// next-cycle implication, sampled on clk, off during rst
`define KWSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("k_way_sorted_merge check failed");

`endif

FILE: hw/rtl/kwsm_pkg.sv
`timescale 1ns / 1ps
package kwsm_pkg;

  // sizing
  localparam int NUM_LISTS  = 8;
  localparam int LIST_DEPTH = 64;
  localparam int LIST_W     = $clog2(NUM_LISTS);
  localparam int POS_W      = $clog2(LIST_DEPTH);
  localparam int OCC_W      = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int TOT_W      = $clog2(MEM_DEPTH + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int ID_W     = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_PULL   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;

  typedef logic [VAL_W-1:0] word_t;

endpackage

FILE: hw/rtl/k_way_sorted_merge.sv
`timescale 1ns / 1ps
// K-way sorted merge. An item is taken when start is high and busy is low; its
// one result shows on the result ports for a single cycle with done high and
// must be taken then, since the block cannot be held off. Append goes through
// the append state; clear, the unused op and a pull on an empty block go
// through the finish state; any other pull goes through the scan, which reads
// each non-empty list's head from the element memory in turn and compares
// it with the best head so far, then scan-end and take. The next item may be
// transferred in the cycle its predecessor's result is shown. Elements live in
// a synchronous memory of NUM_LISTS * LIST_DEPTH words, each list a circular
// buffer; only written entries are ever read, so the memory has no reset pass.
`include "k_way_sorted_merge_assert.svh"

module k_way_sorted_merge import kwsm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     op,
  input  logic [ID_W-1:0]     list_id,
  input  logic signed [VAL_W-1:0] value,
  output logic                done,
  output logic signed [VAL_W-1:0] merged_value,
  output logic [ID_W-1:0]     source_list,
  output logic [STATUS_W-1:0] status,
  output logic                was_last
);

  // states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_APPEND   = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SCAN_END = 3'd3;
  localparam logic [2:0] S_TAKE     = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // item registers
  logic [OP_W-1:0] op_q;
  logic [ID_W-1:0] id_q;
  logic            id_ok;
  word_t           value_q;

  // per-list bookkeeping
  logic [POS_W-1:0] head_index [NUM_LISTS];
  logic [OCC_W-1:0] occupancy  [NUM_LISTS];
  logic [TOT_W-1:0] total;

  // element memory
  word_t              list_store [MEM_DEPTH];
  word_t              mem_rdata;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;

  // scan and compare
  logic [LIST_W-1:0]  scan_idx;
  logic               cmp_vld;
  logic [LIST_W-1:0]  cmp_idx;
  logic               found;
  logic [LIST_W-1:0]  best_idx;
  logic signed [VAL_W-1:0] best_val;

  // shared list pointer and its looked-up values
  logic [LIST_W-1:0]  ptr;
  logic [POS_W-1:0]   ptr_head;
  logic [OCC_W-1:0]   ptr_occ;
  logic [OCC_W:0]     tail_sum;
  logic [POS_W-1:0]   tail_pos;
  logic [POS_W-1:0]   head_inc;
  logic               append_ok;
  logic               accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // one list index per state
  always_comb begin
    unique case (state)
      S_APPEND: ptr = LIST_W'(id_q);
      S_SCAN:   ptr = scan_idx;
      S_TAKE:   ptr = best_idx;
      default:  ptr = '0;
    endcase
  end

  assign ptr_head = head_index[ptr];
  assign ptr_occ  = occupancy[ptr];

  // tail position wraps once at most
  assign tail_sum = (OCC_W + 1)'(ptr_head) + (OCC_W + 1)'(ptr_occ);
  assign tail_pos = (tail_sum >= (OCC_W + 1)'(LIST_DEPTH))
                    ? POS_W'(tail_sum - (OCC_W + 1)'(LIST_DEPTH))
                    : POS_W'(tail_sum);
  assign head_inc = (ptr_head == POS_W'(LIST_DEPTH - 1)) ? '0 : ptr_head + 1'b1;

  assign append_ok = id_ok && (ptr_occ < OCC_W'(LIST_DEPTH));

  // memory addressing
  assign mem_we    = (state == S_APPEND) && append_ok;
  assign mem_waddr = ADDR_W'(ptr) * ADDR_W'(LIST_DEPTH) + ADDR_W'(tail_pos);
  assign mem_re    = (state == S_SCAN) && (ptr_occ != '0);
  assign mem_raddr = ADDR_W'(ptr) * ADDR_W'(LIST_DEPTH) + ADDR_W'(ptr_head);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_store[mem_waddr] <= value_q;
    end
    if (mem_re) begin
      mem_rdata <= list_store[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_APPEND) begin
            state_next = S_APPEND;
          end else if (op == OP_PULL && total != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_APPEND:   state_next = S_IDLE;
      S_SCAN: begin
        if (scan_idx == LIST_W'(NUM_LISTS - 1)) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: state_next = S_TAKE;
      S_TAKE:     state_next = S_IDLE;
      S_FINISH:   state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the transferred item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      id_q    <= list_id;
      id_ok   <= (32'(list_id) < NUM_LISTS);
      value_q <= value;
    end
  end

  // scan counter and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      found    <= 1'b0;
    end else begin
      cmp_vld <= mem_re;
      cmp_idx <= scan_idx;
      if (accept) begin
        scan_idx <= '0;
        found    <= 1'b0;
      end else if (state == S_SCAN) begin
        scan_idx <= scan_idx + 1'b1;
      end
      // strict less-than keeps the lower index on ties
      if (cmp_vld && (!found || $signed(mem_rdata) < best_val)) begin
        found    <= 1'b1;
        best_idx <= cmp_idx;
        best_val <= $signed(mem_rdata);
      end
    end
  end

  // list bookkeeping updates
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_index[i] <= '0;
        occupancy[i]  <= '0;
      end
    end else begin
      case (state)
        S_APPEND: begin
          if (append_ok) begin
            occupancy[ptr] <= ptr_occ + 1'b1;
            total          <= total + 1'b1;
          end
        end
        S_TAKE: begin
          head_index[ptr] <= head_inc;
          occupancy[ptr]  <= ptr_occ - 1'b1;
          total           <= total - 1'b1;
        end
        S_FINISH: begin
          if (op_q == OP_CLEAR) begin
            total <= '0;
            for (int i = 0; i < NUM_LISTS; i++) begin
              head_index[i] <= '0;
              occupancy[i]  <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_APPEND) || (state == S_TAKE) || (state == S_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_APPEND: begin
        merged_value <= '0;
        source_list  <= '0;
        status       <= append_ok ? ST_DONE : ST_DROPPED;
        was_last     <= 1'b0;
      end
      S_TAKE: begin
        merged_value <= best_val;
        source_list  <= ID_W'(best_idx);
        status       <= ST_DONE;
        was_last     <= (total == TOT_W'(1));
      end
      S_FINISH: begin
        merged_value <= '0;
        source_list  <= '0;
        status       <= (op_q == OP_PULL) ? ST_EMPTY : ST_DONE;
        was_last     <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  // checks
  `KWSM_ASSERT_NEXT(a_accept_busy, accept, busy)
  `KWSM_ASSERT_SAME(a_empty_total, done && status == ST_EMPTY, total == '0)
  `KWSM_ASSERT_SAME(a_last_total, done && was_last, total == '0)
  `KWSM_ASSERT_SAME(a_scan_nonempty, state == S_SCAN, total != '0)

endmodule

FILE: tb/tb_k_way_sorted_merge.sv
`timescale 1ns / 1ps

module tb_k_way_sorted_merge;
  import kwsm_pkg::*;

  // op code with no meaning in the block
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // idling stops once this many items have been transferred
  localparam int QUIET_AFTER = 650;
  localparam int ITEM_TARGET = 750;
  // longest pull plus margin
  localparam int SETTLE_CYCLES = NUM_LISTS + 12;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [ID_W-1:0]         src;
    logic [STATUS_W-1:0]     status;
    logic                    last;
  } merge_result_t;

  // shadow of the list store and the results it predicts
  class merge_tracker;
    logic [VAL_W-1:0] elem_mem [NUM_LISTS][LIST_DEPTH];
    logic [POS_W-1:0] head_pos [NUM_LISTS];
    logic [OCC_W-1:0] fill [NUM_LISTS];
    merge_result_t    pending_results [$];
    int               mismatch_count;

    function new();
      for (int i = 0; i < NUM_LISTS; i++) begin
        head_pos[i] = '0;
        fill[i] = '0;
      end
      mismatch_count = 0;
    endfunction

    function int held();
      int sum;
      sum = 0;
      for (int i = 0; i < NUM_LISTS; i++) sum += fill[i];
      return sum;
    endfunction

    function int fill_of(logic [ID_W-1:0] id);
      return fill[id];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // work out the result of one transferred item and update the shadow
    function void accept_item(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                              logic [VAL_W-1:0] val);
      merge_result_t           res;
      logic [POS_W-1:0]        tail;
      logic signed [VAL_W-1:0] head_val;
      logic signed [VAL_W-1:0] best_val;
      int                      best;
      int                      total;
      bit                      found;
      res.value = '0;
      res.src = '0;
      res.status = ST_DONE;
      res.last = 1'b0;
      best_val = '0;
      best = 0;
      total = 0;
      found = 1'b0;
      case (code)
        OP_APPEND: begin
          if (int'(id) >= NUM_LISTS || fill[id] >= LIST_DEPTH) begin
            res.status = ST_DROPPED;
          end else begin
            tail = head_pos[id] + fill[id][POS_W-1:0];
            elem_mem[id][tail] = val;
            fill[id] = fill[id] + 1'b1;
          end
        end
        OP_PULL: begin
          // smallest head wins, lower list on a tie
          for (int i = 0; i < NUM_LISTS; i++) begin
            total += fill[i];
            if (fill[i] != 0) begin
              head_val = elem_mem[i][head_pos[i]];
              if (!found || head_val < best_val) begin
                found = 1'b1;
                best = i;
                best_val = head_val;
              end
            end
          end
          if (!found) begin
            res.status = ST_EMPTY;
          end else begin
            res.value = best_val;
            res.src = best[ID_W-1:0];
            res.last = (total == 1);
            head_pos[best] = head_pos[best] + 1'b1;
            fill[best] = fill[best] - 1'b1;
          end
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_LISTS; i++) begin
            head_pos[i] = '0;
            fill[i] = '0;
          end
        end
        default: ;
      endcase
      pending_results.insert(pending_results.size(), res);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // compare one result with the oldest prediction
    task check_result(logic signed [VAL_W-1:0] got_value, logic [ID_W-1:0] got_src,
                      logic [STATUS_W-1:0] got_status, logic got_last);
      merge_result_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result with none pending: value %0d source %0d status %0d",
                         got_value, got_src, got_status));
        return;
      end
      exp = pending_results.pop_front();
      if (got_value !== exp.value)
        report($sformatf("merged_value %0d, expected %0d", got_value, exp.value));
      if (got_src !== exp.src)
        report($sformatf("source_list %0d, expected %0d", got_src, exp.src));
      if (got_status !== exp.status)
        report($sformatf("status %0d, expected %0d", got_status, exp.status));
      if (got_last !== exp.last)
        report($sformatf("was_last %0b, expected %0b", got_last, exp.last));
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         op = OP_APPEND;
  logic [ID_W-1:0]         list_id = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic                    done;
  logic signed [VAL_W-1:0] merged_value;
  logic [ID_W-1:0]         source_list;
  logic [STATUS_W-1:0]     status;
  logic                    was_last;

  merge_tracker tracker = new();
  int           items_sent = 0;
  bit           idling_on = 1'b1;

  k_way_sorted_merge DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .list_id      (list_id),
    .value        (value),
    .done         (done),
    .merged_value (merged_value),
    .source_list  (source_list),
    .status       (status),
    .was_last     (was_last)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(merged_value, source_list, status, was_last);
  end

  // run limit
  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

  // hold start high until the block takes the item
  task automatic send_item(logic [OP_W-1:0] code, logic [ID_W-1:0] id,
                           logic [VAL_W-1:0] val);
    start <= 1'b1;
    op <= code;
    list_id <= id;
    value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.accept_item(code, id, val);
    items_sent++;
  endtask

  // idle with junk on the fields
  task automatic idle_burst(int cycles);
    if (start) start <= 1'b0;
    op <= OP_W'($urandom_range(0, 3));
    list_id <= ID_W'($urandom_range(0, NUM_LISTS - 1));
    value <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic pause_maybe();
    if (idling_on && $urandom_range(0, 2) == 0) idle_burst($urandom_range(1, 9));
  endtask

  // hold off until every predicted result has come back
  task automatic drain_wait();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic send_pull();
    send_item(OP_PULL, ID_W'($urandom_range(0, NUM_LISTS - 1)), $urandom);
    pause_maybe();
  endtask

  task automatic send_append(logic [ID_W-1:0] id, logic [VAL_W-1:0] val);
    send_item(OP_APPEND, id, val);
    pause_maybe();
  endtask

  // fill several lists with ascending runs, then merge out all or half of what is held
  task automatic run_merge();
    logic [VAL_W-1:0] base;
    logic [VAL_W-1:0] v;
    logic [ID_W-1:0]  id;
    int               nl;
    int               cnt;
    int               pulls;
    base = $urandom;
    nl = $urandom_range(2, NUM_LISTS);
    for (int l = 0; l < nl; l++) begin
      id = ID_W'($urandom_range(0, NUM_LISTS - 1));
      cnt = $urandom_range(1, 8);
      v = base + $urandom_range(0, 3);
      for (int k = 0; k < cnt; k++) begin
        send_append(id, v);
        v = v + $urandom_range(0, 40);
      end
    end
    pulls = ($urandom_range(0, 3) != 0) ? tracker.held() + 1 : tracker.held() / 2;
    repeat (pulls) send_pull();
  endtask

  // push one list past full, then take a few so heads move on
  task automatic run_overflow();
    logic [ID_W-1:0] id;
    int              n;
    id = ID_W'($urandom_range(0, NUM_LISTS - 1));
    n = LIST_DEPTH - tracker.fill_of(id) + $urandom_range(1, 3);
    repeat (n) send_append(id, $urandom);
    repeat ($urandom_range(1, 20)) send_pull();
  endtask

  // any op, any fields
  task automatic run_noise();
    repeat ($urandom_range(1, 10)) begin
      send_item(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, NUM_LISTS - 1)),
                $urandom);
      pause_maybe();
    end
  endtask

  task automatic run_clear();
    if (items_sent < QUIET_AFTER && $urandom_range(0, 1) == 0) drain_wait();
    send_item(OP_CLEAR, ID_W'($urandom_range(0, NUM_LISTS - 1)), $urandom);
    pause_maybe();
    repeat ($urandom_range(1, 3)) send_pull();
  endtask

  initial begin
    int pick;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, ties, unused op, last element, empty pulls
    send_item(OP_CLEAR, 3'd5, 32'hDEAD_BEEF);
    send_pull();
    send_append(3'd0, 32'h8000_0000);
    send_append(3'd7, 32'h7FFF_FFFF);
    send_append(3'd3, 32'd5);
    send_append(3'd2, 32'd5);
    send_append(3'd5, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 3'd6, 32'h1234_5678);
    repeat (6) send_pull();
    send_pull();
    send_append(3'd1, 32'd0);
    send_append(3'd4, 32'd0);
    send_item(OP_CLEAR, 3'd0, 32'd0);
    send_pull();
    send_append(3'd6, 32'd123);
    send_pull();
    send_item(OP_UNUSED, 3'd7, 32'hFFFF_FFFF);

    // sender holds off until the block has answered everything
    drain_wait();

    // random scenarios, half of them merge runs
    while (items_sent < ITEM_TARGET) begin
      idling_on = (items_sent < QUIET_AFTER) && ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 5) run_merge();
      else if (pick == 5) run_overflow();
      else if (pick < 8) run_noise();
      else run_clear();
    end

    // wait for the last results, then let the block settle
    if (start) start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/kwsm_pkg.sv
hw/rtl/k_way_sorted_merge.sv
tb/tb_k_way_sorted_merge.sv
